FILE: hdl/lhdt_pkg.sv
package lhdt_pkg;

   localparam int DEF_TABLE_DEPTH = 128;

   localparam int IP_W     = 32;
   localparam int MAC_W    = 48;
   localparam int ETYPE_W  = 16;
   localparam int TTL_W    = 8;
   localparam int CLASS_W  = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;

   localparam logic [ETYPE_W-1:0] ETH_TYPE_IPV4 = 16'h0800;

   localparam logic [7:0] PRIV_A_OCTET  = 8'd10;
   localparam logic [7:0] PRIV_B_OCTET  = 8'd172;
   localparam logic [7:0] PRIV_B_LOW    = 8'd16;
   localparam logic [7:0] PRIV_B_HIGH   = 8'd31;
   localparam logic [7:0] PRIV_C_OCTET1 = 8'd192;
   localparam logic [7:0] PRIV_C_OCTET2 = 8'd168;

   localparam logic [MAC_W-1:0] MAC_ZERO  = 48'h0000_0000_0000;
   localparam logic [MAC_W-1:0] MAC_BCAST = 48'hffff_ffff_ffff;

   localparam logic [TTL_W-1:0] DEF_UNIX_TTL_LIMIT    = 8'd64;
   localparam logic [TTL_W-1:0] DEF_WINDOWS_TTL_LIMIT = 8'd128;

   localparam logic [CSR_IDX_W-1:0] CSR_UNIX_TTL_LIMIT    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOWS_TTL_LIMIT = 2'd1;

   localparam logic [CLASS_W-1:0] OS_UNIX    = 2'd0;
   localparam logic [CLASS_W-1:0] OS_WINDOWS = 2'd1;
   localparam logic [CLASS_W-1:0] OS_ROUTER  = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SRC_CHK,
      ST_SRC_SCAN,
      ST_DST_CHK,
      ST_DST_SCAN,
      ST_FINISH,
      ST_EMIT_SRC,
      ST_EMIT_DST
   } lhdt_state_type;

   typedef struct packed {
      logic capture;
      logic scan_start;
      logic scan_step;
      logic insert;
      logic sel;
   } lhdt_cmd_type;

   typedef struct packed {
      logic src_cand;
      logic dst_cand;
      logic scan_done;
      logic scan_match;
      logic src_new;
      logic dst_new;
   } lhdt_status_type;

   function automatic logic is_private(input logic [IP_W-1:0] ip);
      logic [7:0] a;
      logic [7:0] b;
      a = ip[31:24];
      b = ip[23:16];
      return (a == PRIV_A_OCTET) ||
             ((a == PRIV_B_OCTET) && (b >= PRIV_B_LOW) && (b <= PRIV_B_HIGH)) ||
             ((a == PRIV_C_OCTET1) && (b == PRIV_C_OCTET2));
   endfunction

   function automatic logic mac_ok(input logic [MAC_W-1:0] mac);
      return (mac != MAC_ZERO) && (mac != MAC_BCAST);
   endfunction

   function automatic logic [CLASS_W-1:0] classify(input logic [TTL_W-1:0] ttl,
                                                   input logic [TTL_W-1:0] unix_limit,
                                                   input logic [TTL_W-1:0] win_limit);
      logic [CLASS_W-1:0] cls;
      if (ttl <= unix_limit) begin
         cls = OS_UNIX;
      end else if (ttl <= win_limit) begin
         cls = OS_WINDOWS;
      end else begin
         cls = OS_ROUTER;
      end
      return cls;
   endfunction

endpackage

FILE: hdl/lan_host_discovery_table.sv
// Learns private IPv4 hosts from parsed Ethernet frame headers.
// The request channel (req_valid/req_stall) carries one header per beat.
// For IPv4 frames the source, then the destination, address is checked
// against a table of seen addresses; a new private address with a usable
// MAC is stored and reported on the response channel (rsp_valid/rsp_stall)
// with an OS class from the TTL. A frame gives zero, one or two beats, and
// rsp_last marks the final beat of a frame.
// The table is searched one entry per cycle through the registered read
// port of a RAM. A search covers only the stored addresses and is skipped
// for an address that needs none; a search ends early on a hit.
// One header is handled at a time; req_stall stays high from acceptance
// until the last response beat is taken.
// When the receiver stalls, the response beat holds and the block waits.
// Reset empties the table and restores the TTL limits to 64 and 128; no
// clearing pass is needed. TTL limits are written on the always-ready csr
// channel; do so only while no header is in progress: it is not checked.
module lan_host_discovery_table #(
   parameter int TABLE_DEPTH = lhdt_pkg::DEF_TABLE_DEPTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [lhdt_pkg::ETYPE_W-1:0]    req_ether_type,
   input  logic [lhdt_pkg::IP_W-1:0]       req_source_ip,
   input  logic [lhdt_pkg::IP_W-1:0]       req_dest_ip,
   input  logic [lhdt_pkg::MAC_W-1:0]      req_source_mac,
   input  logic [lhdt_pkg::MAC_W-1:0]      req_dest_mac,
   input  logic [lhdt_pkg::TTL_W-1:0]      req_hop_limit,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [lhdt_pkg::IP_W-1:0]       rsp_host_ip,
   output logic [lhdt_pkg::MAC_W-1:0]      rsp_host_mac,
   output logic [lhdt_pkg::CLASS_W-1:0]    rsp_os_class,
   output logic                            rsp_last,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [lhdt_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [lhdt_pkg::CSR_DATA_W-1:0] csr_data
);

   import lhdt_pkg::*;

   lhdt_cmd_type    cmd;
   lhdt_status_type status;

   assign csr_ready = 1'b1;

   lhdt_controller u_controller (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .status   (status),
      .cmd      (cmd)
   );

   lhdt_datapath #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .csr_write     (csr_valid && csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .req_ether_type(req_ether_type),
      .req_source_ip (req_source_ip),
      .req_dest_ip   (req_dest_ip),
      .req_source_mac(req_source_mac),
      .req_dest_mac  (req_dest_mac),
      .req_hop_limit (req_hop_limit),
      .cmd           (cmd),
      .status        (status),
      .rsp_host_ip   (rsp_host_ip),
      .rsp_host_mac  (rsp_host_mac),
      .rsp_os_class  (rsp_os_class),
      .rsp_last      (rsp_last)
   );

endmodule

FILE: hdl/lhdt_ram.sv
module lhdt_ram #(
   parameter int WIDTH  = 32,
   parameter int DEPTH  = 128,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

endmodule

FILE: hdl/lhdt_controller.sv
module lhdt_controller (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   input  lhdt_pkg::lhdt_status_type status,
   output lhdt_pkg::lhdt_cmd_type    cmd
);

   import lhdt_pkg::*;

   lhdt_state_type state_ff;
   lhdt_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_SRC_CHK;
            end
         end
         ST_SRC_CHK: begin
            state_in = status.src_cand ? ST_SRC_SCAN : ST_DST_CHK;
         end
         ST_SRC_SCAN: begin
            if (status.scan_done) begin
               state_in = ST_DST_CHK;
            end
         end
         ST_DST_CHK: begin
            state_in = status.dst_cand ? ST_DST_SCAN : ST_FINISH;
         end
         ST_DST_SCAN: begin
            if (status.scan_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            priority if (status.src_new) begin
               state_in = ST_EMIT_SRC;
            end else if (status.dst_new) begin
               state_in = ST_EMIT_DST;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_EMIT_SRC: begin
            if (!rsp_stall) begin
               state_in = status.dst_new ? ST_EMIT_DST : ST_IDLE;
            end
         end
         ST_EMIT_DST: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall   = 1'b0;
            cmd.capture = req_valid;
         end
         ST_SRC_CHK: begin
            cmd.scan_start = status.src_cand;
         end
         ST_SRC_SCAN: begin
            cmd.scan_step = 1'b1;
            cmd.insert    = status.scan_done && !status.scan_match;
         end
         ST_DST_CHK: begin
            cmd.sel        = 1'b1;
            cmd.scan_start = status.dst_cand;
         end
         ST_DST_SCAN: begin
            cmd.sel       = 1'b1;
            cmd.scan_step = 1'b1;
            cmd.insert    = status.scan_done && !status.scan_match;
         end
         ST_FINISH: begin
         end
         ST_EMIT_SRC: begin
            rsp_valid = 1'b1;
         end
         ST_EMIT_DST: begin
            cmd.sel   = 1'b1;
            rsp_valid = 1'b1;
         end
         default: begin
         end
      endcase
   end

endmodule

FILE: hdl/lhdt_datapath.sv
module lhdt_datapath #(
   parameter int TABLE_DEPTH = lhdt_pkg::DEF_TABLE_DEPTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write,
   input  logic [lhdt_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [lhdt_pkg::CSR_DATA_W-1:0]     csr_data,
   input  logic [lhdt_pkg::ETYPE_W-1:0]        req_ether_type,
   input  logic [lhdt_pkg::IP_W-1:0]           req_source_ip,
   input  logic [lhdt_pkg::IP_W-1:0]           req_dest_ip,
   input  logic [lhdt_pkg::MAC_W-1:0]          req_source_mac,
   input  logic [lhdt_pkg::MAC_W-1:0]          req_dest_mac,
   input  logic [lhdt_pkg::TTL_W-1:0]          req_hop_limit,
   input  lhdt_pkg::lhdt_cmd_type              cmd,
   output lhdt_pkg::lhdt_status_type           status,
   output logic [lhdt_pkg::IP_W-1:0]           rsp_host_ip,
   output logic [lhdt_pkg::MAC_W-1:0]          rsp_host_mac,
   output logic [lhdt_pkg::CLASS_W-1:0]        rsp_os_class,
   output logic                                rsp_last
);

   import lhdt_pkg::*;

   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   logic [TTL_W-1:0] unix_limit_ff, unix_limit_in;
   logic [TTL_W-1:0] win_limit_ff, win_limit_in;
   logic             src_cand_ff, src_cand_in;
   logic             dst_cand_ff, dst_cand_in;
   logic             src_new_ff, src_new_in;
   logic             dst_new_ff, dst_new_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [CW-1:0]    idx_ff, idx_in;
   logic             pend_ff, pend_in;

   logic [IP_W-1:0]  sip_ff, dip_ff;
   logic [MAC_W-1:0] smac_ff, dmac_ff;
   logic [TTL_W-1:0] ttl_ff;

   logic             is_ipv4;
   logic [IP_W-1:0]  key;
   logic             idx_live;
   logic             match;
   logic             full;
   logic             rd_en;
   logic [AW-1:0]    rd_addr;
   logic [AW-1:0]    wr_addr;
   logic [IP_W-1:0]  rd_data;

   lhdt_ram #(
      .WIDTH (IP_W),
      .DEPTH (TABLE_DEPTH),
      .ADDR_W(AW)
   ) u_seen_ram (
      .clock     (clock),
      .wr_en     (cmd.insert),
      .wr_addr   (wr_addr),
      .wr_data   (key),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_data_ff(rd_data)
   );

   assign is_ipv4  = (req_ether_type == ETH_TYPE_IPV4);
   assign key      = cmd.sel ? dip_ff : sip_ff;
   assign idx_live = (idx_ff < count_ff);
   assign match    = pend_ff && (rd_data == key);
   assign full     = (count_ff == CW'(TABLE_DEPTH));
   assign rd_en    = cmd.scan_step && idx_live;
   assign rd_addr  = idx_ff[AW-1:0];
   assign wr_addr  = full ? '0 : count_ff[AW-1:0];

   always_comb begin
      unix_limit_in = unix_limit_ff;
      win_limit_in  = win_limit_ff;
      if (csr_write) begin
         if (csr_index == CSR_UNIX_TTL_LIMIT) begin
            unix_limit_in = csr_data;
         end
         if (csr_index == CSR_WINDOWS_TTL_LIMIT) begin
            win_limit_in = csr_data;
         end
      end
   end

   always_comb begin
      src_cand_in = src_cand_ff;
      dst_cand_in = dst_cand_ff;
      src_new_in  = src_new_ff;
      dst_new_in  = dst_new_ff;
      if (cmd.capture) begin
         src_cand_in = is_ipv4 && is_private(req_source_ip) && mac_ok(req_source_mac);
         dst_cand_in = is_ipv4 && is_private(req_dest_ip) && mac_ok(req_dest_mac);
         src_new_in  = 1'b0;
         dst_new_in  = 1'b0;
      end
      if (cmd.insert) begin
         if (cmd.sel) begin
            dst_new_in = 1'b1;
         end else begin
            src_new_in = 1'b1;
         end
      end
   end

   always_comb begin
      idx_in   = idx_ff;
      pend_in  = pend_ff;
      count_in = count_ff;
      if (cmd.scan_start) begin
         idx_in  = '0;
         pend_in = 1'b0;
      end else if (cmd.scan_step) begin
         pend_in = idx_live;
         if (idx_live) begin
            idx_in = idx_ff + CW'(1);
         end
      end
      if (cmd.insert) begin
         count_in = full ? CW'(1) : count_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         unix_limit_ff <= DEF_UNIX_TTL_LIMIT;
         win_limit_ff  <= DEF_WINDOWS_TTL_LIMIT;
         src_cand_ff   <= 1'b0;
         dst_cand_ff   <= 1'b0;
         src_new_ff    <= 1'b0;
         dst_new_ff    <= 1'b0;
         count_ff      <= '0;
         idx_ff        <= '0;
         pend_ff       <= 1'b0;
      end else begin
         unix_limit_ff <= unix_limit_in;
         win_limit_ff  <= win_limit_in;
         src_cand_ff   <= src_cand_in;
         dst_cand_ff   <= dst_cand_in;
         src_new_ff    <= src_new_in;
         dst_new_ff    <= dst_new_in;
         count_ff      <= count_in;
         idx_ff        <= idx_in;
         pend_ff       <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         sip_ff  <= req_source_ip;
         dip_ff  <= req_dest_ip;
         smac_ff <= req_source_mac;
         dmac_ff <= req_dest_mac;
         ttl_ff  <= req_hop_limit;
      end
   end

   always_comb begin
      status            = '0;
      status.src_cand   = src_cand_ff;
      status.dst_cand   = dst_cand_ff;
      status.scan_done  = match || (!idx_live && !pend_ff);
      status.scan_match = match;
      status.src_new    = src_new_ff;
      status.dst_new    = dst_new_ff;
   end

   assign rsp_host_ip  = cmd.sel ? dip_ff : sip_ff;
   assign rsp_host_mac = cmd.sel ? dmac_ff : smac_ff;
   assign rsp_os_class = classify(ttl_ff, unix_limit_ff, win_limit_ff);
   assign rsp_last     = cmd.sel || !dst_new_ff;

endmodule

FILE: hdl/lhdt_checker.sv
module lhdt_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_stall,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic rsp_last
);

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response beat right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response beat dropped while stalled");

   a_one_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("header accepted while a response is pending");

   a_pair: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last |=> rsp_valid)
      else $error("second response of a frame is missing");

   a_no_instant: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> !rsp_valid)
      else $error("response beat in the cycle after acceptance");

endmodule

bind lan_host_discovery_table lhdt_checker u_checker (.*);
